@@ hdl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue unit: operation and
// status codes, field widths and the control structs passed between stages.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;
  localparam int OCC_W     = 11;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_TAIL = 3'd0,
    OP_PUSH_HEAD = 3'd1,
    OP_POP_TAIL  = 3'd2,
    OP_POP_HEAD  = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // Memory port strobes for the beat being accepted
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // Per-beat result information carried alongside the memory read
  typedef struct packed {
    logic    pop_ok;
    status_t status;
  } beat_info_t;

endpackage

@@ hdl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Head, tail and count registers of the ring. Decodes the accepted beat,
// issues the ring memory read or write and reports status and occupancy.
// ----------------------------------------------------------------------------
module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [deq_pkg::OP_W-1:0]          op_in,
  input  logic signed [deq_pkg::DATA_W-1:0] data_in,
  output deq_pkg::mem_ctl_t                 mem_ctl,
  output logic [$clog2(DEPTH)-1:0]          mem_addr,
  output logic [deq_pkg::DATA_W-1:0]        mem_wdata,
  output deq_pkg::beat_info_t               info,
  output logic [deq_pkg::OCC_W-1:0]         occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic          full, empty;
  logic          wr, rd;
  logic [deq_pkg::OCC_W+CW-1:0] occ_ext;
  deq_pkg::op_t  op;

  // Ring neighbors with wrap at the store depth
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign tail_inc = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
  assign tail_dec = (tail_r == '0) ? AW'(DEPTH - 1) : tail_r - AW'(1);

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign op    = deq_pkg::op_t'(op_in);

  // Decode the operation against the current ring state
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    wr          = 1'b0;
    rd          = 1'b0;
    mem_addr    = head_r;
    info.pop_ok = 1'b0;
    info.status = deq_pkg::ST_OK;
    case (op)
      deq_pkg::OP_PUSH_TAIL: begin
        if (full) begin
          info.status = deq_pkg::ST_OVERFLOW;
        end else begin
          wr        = 1'b1;
          mem_addr  = tail_r;
          tail_nxt  = tail_inc;
          count_nxt = count_r + CW'(1);
        end
      end
      deq_pkg::OP_PUSH_HEAD: begin
        if (full) begin
          info.status = deq_pkg::ST_OVERFLOW;
        end else begin
          wr        = 1'b1;
          mem_addr  = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      deq_pkg::OP_POP_TAIL: begin
        if (empty) begin
          info.status = deq_pkg::ST_UNDERFLOW;
        end else begin
          rd          = 1'b1;
          info.pop_ok = 1'b1;
          mem_addr    = tail_dec;
          tail_nxt    = tail_dec;
          count_nxt   = count_r - CW'(1);
        end
      end
      deq_pkg::OP_POP_HEAD: begin
        if (empty) begin
          info.status = deq_pkg::ST_UNDERFLOW;
        end else begin
          rd          = 1'b1;
          info.pop_ok = 1'b1;
          mem_addr    = head_r;
          head_nxt    = head_inc;
          count_nxt   = count_r - CW'(1);
        end
      end
      deq_pkg::OP_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Strobe the memory only for the accepted beat
  assign mem_ctl.wr_en = accept & wr;
  assign mem_ctl.rd_en = accept & rd;
  assign mem_wdata     = data_in;

  // Occupancy wraps within its field width
  assign occ_ext   = {{deq_pkg::OCC_W{1'b0}}, count_nxt};
  assign occupancy = occ_ext[deq_pkg::OCC_W-1:0];

  // Advance ring pointers on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ hdl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// Single-port ring store with registered read data. A beat either writes or
// reads one entry; the read data holds until the next read.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  deq_pkg::mem_ctl_t          mem_ctl,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  input  logic [deq_pkg::DATA_W-1:0] wdata,
  output logic [deq_pkg::DATA_W-1:0] rdata
);

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [deq_pkg::DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/deq_outq.sv @@
// ----------------------------------------------------------------------------
// deq_outq
// Read stage and output register. The read stage waits for the memory data;
// the output register holds a finished result while the receiver stalls.
// ----------------------------------------------------------------------------
module deq_outq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  deq_pkg::beat_info_t               info,
  input  logic [deq_pkg::OCC_W-1:0]         occ_in,
  input  logic [deq_pkg::DATA_W-1:0]        rdata,
  output logic                              ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [deq_pkg::DATA_W-1:0] out_data_out,
  output logic [deq_pkg::ST_W-1:0]          out_status,
  output logic [deq_pkg::OCC_W-1:0]         out_occupancy
);

  logic                        s1_valid_r, s1_valid_nxt;
  deq_pkg::beat_info_t         s1_info_r;
  logic [deq_pkg::OCC_W-1:0]   s1_occ_r;
  logic                        o_valid_r, o_valid_nxt;
  logic [deq_pkg::DATA_W-1:0]  o_data_r;
  deq_pkg::status_t            o_status_r;
  logic [deq_pkg::OCC_W-1:0]   o_occ_r;
  logic                        s1_adv;

  // Move the read stage on when the output register is free or draining
  assign s1_adv = s1_valid_r & (~o_valid_r | out_ready);
  assign ready  = ~s1_valid_r | ~o_valid_r | out_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    o_valid_nxt = o_valid_r;
    if (s1_adv) begin
      o_valid_nxt = 1'b1;
    end else if (out_ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  // Payload: capture beat info, then the result with memory data
  always_ff @(posedge clk) begin
    if (load) begin
      s1_info_r <= info;
      s1_occ_r  <= occ_in;
    end
    if (s1_adv) begin
      o_data_r   <= s1_info_r.pop_ok ? rdata : '0;
      o_status_r <= s1_info_r.status;
      o_occ_r    <= s1_occ_r;
    end
  end

  assign out_valid     = o_valid_r;
  assign out_data_out  = o_data_r;
  assign out_status    = o_status_r;
  assign out_occupancy = o_occ_r;

endmodule

@@ hdl/double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed 32-bit words in a ring memory of DEPTH entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_ready): in_operation selects push tail, push head,
//   pop tail, pop head or clear; in_data_in is the word pushed.
//   Result beat (out_valid/out_ready): one per input beat, in order, with
//   the popped word (zero unless a pop succeeds), a status (ok, underflow,
//   overflow) and the occupancy after the operation, modulo 2^11.
//   Pipeline: at accept the ring memory registers the read data and the read
//   stage takes the beat info; the result then moves to the output register.
//   Throughput: one beat per cycle while in_ready is high; each beat uses the
//   single memory port at most once, write or read; pointers move on accept.
//   Reset: head, tail and count go to zero and both stages empty; memory
//   contents are not cleared and need no clearing pass.
//   Stall: a held result stays stable in the output register; one more beat
//   is taken into the read stage, then in_ready drops until out_ready.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [deq_pkg::OP_W-1:0]          in_operation,
  input  logic signed [deq_pkg::DATA_W-1:0] in_data_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [deq_pkg::DATA_W-1:0] out_data_out,
  output logic [deq_pkg::ST_W-1:0]          out_status,
  output logic [deq_pkg::OCC_W-1:0]         out_occupancy
);

  localparam int AW = $clog2(DEPTH);

  logic                       accept;
  deq_pkg::mem_ctl_t          mem_ctl;
  logic [AW-1:0]              mem_addr;
  logic [deq_pkg::DATA_W-1:0] mem_wdata;
  logic [deq_pkg::DATA_W-1:0] mem_rdata;
  deq_pkg::beat_info_t        info;
  logic [deq_pkg::OCC_W-1:0]  occ;

  assign accept = in_valid & in_ready;

  deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op_in     (in_operation),
    .data_in   (in_data_in),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .info      (info),
    .occupancy (occ)
  );

  deq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata   (mem_rdata)
  );

  deq_outq u_outq (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (accept),
    .info          (info),
    .occ_in        (occ),
    .rdata         (mem_rdata),
    .ready         (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data_out  (out_data_out),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

endmodule

@@ hdl/deq_checker.sv @@
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the deque unit, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [deq_pkg::DATA_W-1:0] out_data_out,
  input logic [deq_pkg::ST_W-1:0]          out_status,
  input logic [deq_pkg::OCC_W-1:0]         out_occupancy
);

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out)
      && $stable(out_status) && $stable(out_occupancy))
    else $error("stalled result beat changed");

  // Underflow only on an empty queue, with no word returned
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == deq_pkg::ST_UNDERFLOW |->
      out_occupancy == '0 && out_data_out == '0)
    else $error("underflow result inconsistent");

  // Overflow only on a full queue, with no word returned
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == deq_pkg::ST_OVERFLOW |->
      out_occupancy == deq_pkg::OCC_W'(DEPTH) && out_data_out == '0)
    else $error("overflow result inconsistent");

  // Drop result valid after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind double_ended_queue_unit deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_data_out  (out_data_out),
  .out_status    (out_status),
  .out_occupancy (out_occupancy)
);
